/* rtl/core/pso_pkg.sv */
// ----------------------------------------------------------------------------
// pso_pkg: shared constants and types for the polar sector occupancy block
// Widths, tangent constants, reset radii and the product-stage record.
// ----------------------------------------------------------------------------
package pso_pkg;

  localparam int RINGS_DEF = 4;
  localparam int RINGS_MAX = 4;
  localparam int SECTORS   = 12;
  localparam int SECT_HALF = 6;
  localparam int MAP_W     = 48;
  localparam int RAD_W     = 15;
  localparam int RSQ_W     = 2 * RAD_W;
  localparam int CFG_IDX_W = 2;
  localparam int COORD_W   = 16;
  localparam int MAG_W     = COORD_W + 1;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int DSQ_W     = SQ_W + 1;
  localparam int Q_FRAC    = 16;
  localparam int TAN_C_W   = 18;
  localparam int TAN_W     = MAG_W + TAN_C_W;
  localparam int RING_W    = 2;
  localparam int SECT_W    = 4;
  localparam int BIT_W     = 6;

  // Tangents of 15 and 75 degrees, unsigned Q16, rounded to nearest.
  localparam logic [TAN_C_W-1:0] TAN15_Q16 = 18'd17560;
  localparam logic [TAN_C_W-1:0] TAN75_Q16 = 18'd244584;

  localparam logic [RAD_W-1:0] RADIUS_RST [RINGS_MAX] = '{
    15'd150, 15'd450, 15'd550, 15'd1000
  };

  typedef struct packed {
    logic [SQ_W-1:0]  x_sq;
    logic [SQ_W-1:0]  y_sq;
    logic [TAN_W-1:0] a_q;
    logic [TAN_W-1:0] b15;
    logic [TAN_W-1:0] b45;
    logic [TAN_W-1:0] b75;
    logic             zero;
    logic             xneg;
    logic             yneg;
    logic             last;
  } pso_prod_t;

endpackage

/* rtl/core/pso_in_if.sv */
// ----------------------------------------------------------------------------
// pso_in_if: point input channel
// Valid/ready channel carrying one planar point and its end-of-scan flag.
// ----------------------------------------------------------------------------
interface pso_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pso_pkg::COORD_W-1:0]  point_x;
  logic signed [pso_pkg::COORD_W-1:0]  point_y;
  logic                                scan_last;

  modport source (output valid, output point_x, output point_y, output scan_last,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input scan_last,
                  output ready);
endinterface

/* rtl/core/pso_out_if.sv */
// ----------------------------------------------------------------------------
// pso_out_if: occupancy map output channel
// Valid/ready channel carrying one 48-bit ring/sector occupancy map.
// ----------------------------------------------------------------------------
interface pso_out_if;
  logic                        valid;
  logic                        ready;
  logic [pso_pkg::MAP_W-1:0]   occupied_map;

  modport source (output valid, output occupied_map, input ready);
  modport sink   (input valid, input occupied_map, output ready);
endinterface

/* rtl/core/polar_sector_occupancy.sv */
// ----------------------------------------------------------------------------
// polar_sector_occupancy: ring/sector occupancy map of planar obstacle points
//
// in_pt carries one point per transfer: signed x (forward) and y (left) in
// millimetres, plus scan_last. Each point within the outermost ring sets one
// bit ring*12+sector of a 48-bit map; the point with scan_last set also
// causes one out_map transfer of the whole map, which is then cleared.
// Points beyond every ring set nothing. cfg_we/cfg_index/cfg_data write the
// ring radii (index 0 is the innermost); write them only while idle.
//
// Path: a final point passes the input, product and output registers.
// Throughput: one point per cycle, set by the squaring and tangent multiplier
// stage. Non-final points keep flowing while a map waits in the output
// register; a stalled receiver only holds back the next final point.
// Reset (rst_n low at a clock edge) restores the default radii
// 150/450/550/1000 mm, clears the map and empties the pipeline.
// ----------------------------------------------------------------------------
module polar_sector_occupancy #(
  parameter int RINGS = pso_pkg::RINGS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  pso_in_if.sink                        in_pt,
  pso_out_if.source                     out_map,
  input  logic                          cfg_we,
  input  logic [pso_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pso_pkg::RAD_W-1:0]     cfg_data
);
  import pso_pkg::*;

  // Squared radii, registered from the radius registers.
  logic [RSQ_W-1:0] rsq [RINGS];

  // Product stage handshake: fin_take drains it into the accumulator.
  logic      s1_valid;
  pso_prod_t s1_data;
  logic      fin_take;

  pso_radius_regs #(.RINGS(RINGS)) u_radius (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rsq       (rsq)
  );

  // Input register, then squares and tangent products.
  pso_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_pt),
    .fin_take (fin_take),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  // Compare, pick the cell, accumulate, and hold the result for transfer.
  pso_accum #(.RINGS(RINGS)) u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_data  (s1_data),
    .rsq      (rsq),
    .fin_take (fin_take),
    .out_ch   (out_map)
  );

endmodule

/* rtl/core/pso_radius_regs.sv */
// ----------------------------------------------------------------------------
// pso_radius_regs: ring radius registers
// Holds the ring radii and keeps a registered square of each for the range test.
// ----------------------------------------------------------------------------
module pso_radius_regs #(
  parameter int RINGS = pso_pkg::RINGS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pso_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pso_pkg::RAD_W-1:0]     cfg_data,
  output logic [pso_pkg::RSQ_W-1:0]     rsq [RINGS]
);
  import pso_pkg::*;

  logic [RAD_W-1:0] radius_r [RINGS];
  logic [RSQ_W-1:0] rsq_r    [RINGS];

  // Writes to an index past the ring count are dropped.
  always_ff @(posedge clk) begin
    for (int i = 0; i < RINGS; i++) begin
      if (!rst_n) begin
        radius_r[i] <= RADIUS_RST[i];
      end else if (cfg_we && (cfg_index == CFG_IDX_W'(i))) begin
        radius_r[i] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RINGS; i++) begin
      rsq_r[i] <= RSQ_W'(radius_r[i]) * RSQ_W'(radius_r[i]);
    end
  end

  assign rsq = rsq_r;

endmodule

/* rtl/core/pso_front.sv */
// ----------------------------------------------------------------------------
// pso_front: input register and product stage
// Registers point magnitudes, then registers squares and tangent products.
// ----------------------------------------------------------------------------
module pso_front (
  input  logic               clk,
  input  logic               rst_n,
  pso_in_if.sink             in_ch,
  input  logic               fin_take,
  output logic               s1_valid,
  output pso_pkg::pso_prod_t s1_data
);
  import pso_pkg::*;

  logic             s0_v_r, s0_v_nxt;
  logic [MAG_W-1:0] ax_r, ay_r;
  logic             xneg_r, yneg_r, last_r;
  logic             s1_v_r, s1_v_nxt;
  pso_prod_t        s1_r, s1_nxt;

  logic                    in_take, s0_adv, s1_free;
  logic signed [MAG_W-1:0] xs, ys;
  logic [MAG_W-1:0]        ax, ay;

  assign s1_free     = !s1_v_r || fin_take;
  assign s0_adv      = s0_v_r && s1_free;
  assign in_ch.ready = !s0_v_r || s1_free;
  assign in_take     = in_ch.valid && in_ch.ready;

  // Sign-extend by one bit so that the magnitude of -32768 fits.
  assign xs = MAG_W'(in_ch.point_x);
  assign ys = MAG_W'(in_ch.point_y);
  assign ax = xs[MAG_W-1] ? MAG_W'(-xs) : MAG_W'(xs);
  assign ay = ys[MAG_W-1] ? MAG_W'(-ys) : MAG_W'(ys);

  always_comb begin
    s0_v_nxt = s0_v_r;
    if (in_take) begin
      s0_v_nxt = 1'b1;
    end else if (s0_adv) begin
      s0_v_nxt = 1'b0;
    end
  end

  always_comb begin
    s1_nxt.x_sq = SQ_W'(ax_r) * SQ_W'(ax_r);
    s1_nxt.y_sq = SQ_W'(ay_r) * SQ_W'(ay_r);
    s1_nxt.a_q  = TAN_W'(ay_r) << Q_FRAC;
    s1_nxt.b15  = TAN_W'(ax_r) * TAN_W'(TAN15_Q16);
    s1_nxt.b45  = TAN_W'(ax_r) << Q_FRAC;
    s1_nxt.b75  = TAN_W'(ax_r) * TAN_W'(TAN75_Q16);
    s1_nxt.zero = (ax_r == '0) && (ay_r == '0);
    s1_nxt.xneg = xneg_r;
    s1_nxt.yneg = yneg_r;
    s1_nxt.last = last_r;
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (s0_adv) begin
      s1_v_nxt = 1'b1;
    end else if (fin_take) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
    end else begin
      s0_v_r <= s0_v_nxt;
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ax_r   <= ax;
      ay_r   <= ay;
      xneg_r <= xs[MAG_W-1];
      yneg_r <= ys[MAG_W-1];
      last_r <= in_ch.scan_last;
    end
    if (s0_adv) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1_valid = s1_v_r;
  assign s1_data  = s1_r;

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !fin_take) |=> (s1_v_r && $stable(s1_r)))
    else $error("product stage lost or changed while held");

  a_s0_move: assert property (@(posedge clk) disable iff (!rst_n)
    s0_adv |=> s1_v_r)
    else $error("point advanced but product stage not valid");

endmodule

/* rtl/core/pso_accum.sv */
// ----------------------------------------------------------------------------
// pso_accum: ring/sector classification and map accumulation
// Picks the cell of each point, sets its bit, and emits the map on scan end.
// ----------------------------------------------------------------------------
module pso_accum #(
  parameter int RINGS = pso_pkg::RINGS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      s1_valid,
  input  pso_pkg::pso_prod_t        s1_data,
  input  logic [pso_pkg::RSQ_W-1:0] rsq [RINGS],
  output logic                      fin_take,
  pso_out_if.source                 out_ch
);
  import pso_pkg::*;

  localparam logic [MAP_W:0]   USED_ONE  = (MAP_W + 1)'(1) << (RINGS * SECTORS);
  localparam logic [MAP_W-1:0] USED_MASK = MAP_W'(USED_ONE - 1'b1);

  logic [MAP_W-1:0]  map_r, map_nxt;
  logic              out_v_r, out_v_nxt;
  logic [MAP_W-1:0]  out_data_r;

  logic [DSQ_W-1:0]  dsq;
  logic              hit;
  logic [RING_W-1:0] ring;
  logic              c15, c45, c75;
  logic [1:0]        n_cnt;
  logic [SECT_W-1:0] s_half, sector;
  logic [BIT_W-1:0]  bit_idx;
  logic [MAP_W-1:0]  set_vec, merged;
  logic              take_last;

  // First ring in index order whose squared radius exceeds the squared distance.
  always_comb begin
    dsq  = DSQ_W'(s1_data.x_sq) + DSQ_W'(s1_data.y_sq);
    hit  = 1'b0;
    ring = '0;
    for (int i = RINGS - 1; i >= 0; i--) begin
      if (dsq < DSQ_W'(rsq[i])) begin
        hit  = 1'b1;
        ring = RING_W'(i);
      end
    end
  end

  // Boundary angles go away from 0 degrees: >= on the +x half, > on the -x half.
  always_comb begin
    if (s1_data.xneg) begin
      c15 = s1_data.a_q > s1_data.b15;
      c45 = s1_data.a_q > s1_data.b45;
      c75 = s1_data.a_q > s1_data.b75;
    end else begin
      c15 = s1_data.a_q >= s1_data.b15;
      c45 = s1_data.a_q >= s1_data.b45;
      c75 = s1_data.a_q >= s1_data.b75;
    end
    n_cnt  = {1'b0, c15} + {1'b0, c45} + {1'b0, c75};
    s_half = s1_data.xneg ? SECT_W'(SECT_HALF) - SECT_W'(n_cnt) : SECT_W'(n_cnt);
    if (s1_data.zero) begin
      sector = '0;
    end else if (s1_data.yneg && (s_half != '0)) begin
      sector = SECT_W'(SECTORS) - s_half;
    end else begin
      sector = s_half;
    end
  end

  always_comb begin
    bit_idx = BIT_W'(ring) * BIT_W'(SECTORS) + BIT_W'(sector);
    set_vec = hit ? (MAP_W'(1) << bit_idx) : '0;
    merged  = map_r | set_vec;
  end

  // A non-final point never waits on the output register.
  assign fin_take  = s1_valid && (!s1_data.last || !out_v_r || out_ch.ready);
  assign take_last = fin_take && s1_data.last;

  always_comb begin
    map_nxt = map_r;
    if (fin_take) begin
      map_nxt = s1_data.last ? '0 : merged;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (take_last) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      map_r   <= map_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_last) begin
      out_data_r <= merged;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.occupied_map = out_data_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ch.ready) |-> !take_last)
    else $error("pending map overwritten");

  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    take_last |=> (out_v_r && (map_r == '0)))
    else $error("map not emitted and cleared at scan end");

  a_unused_cells: assert property (@(posedge clk) disable iff (!rst_n)
    (map_r & ~USED_MASK) == '0)
    else $error("bit set beyond the configured rings");

endmodule

/* test/polar_sector_occupancy_tb.sv */
// ----------------------------------------------------------------------------
// polar_sector_occupancy_tb: self-checking bench for the ring/sector map block
// Streams planar points through the block under several ring-radius settings
// (defaults, all maximum, all zero, out of order, random, tiny). A scoreboard
// class predicts every emitted 48-bit occupancy map and checks it on arrival.
// Both handshakes idle at random, and the map receiver holds off for long
// stretches so that the block backs up and stalls its point input.
// ----------------------------------------------------------------------------
module polar_sector_occupancy_tb;
  import pso_pkg::*;

  // Register indexes of the configuration port, innermost ring first.
  typedef enum logic [CFG_IDX_W-1:0] {
    RING0_RADIUS, RING1_RADIUS, RING2_RADIUS, RING3_RADIUS
  } radius_reg_e;

  localparam int unsigned TAN45_Q1616 = 65536;  // tan 45 in Q16
  localparam int DRAIN_CYCLES = 8;               // settling wait after the last queued map arrives
  localparam int HOLD_CYCLES  = 400;             // long receiver hold-off
  localparam int CYCLE_LIMIT  = 300000;
  localparam int IDLE_PCT     = 28;
  localparam int MAX_SCAN     = 24;
  localparam int PLANS        = 6;
  localparam int RANDOM_PLAN  = 4;
  localparam int DIRECTED_N   = 23;

  // --------------------------------------------------------------------------
  // Occupancy scoreboard: mirrors the radii and the map under construction,
  // queues the map due on every final point and checks maps as they arrive.
  // --------------------------------------------------------------------------
  class occupancy_scoreboard;
    logic [RAD_W-1:0] radius [RINGS_MAX];
    logic [MAP_W-1:0] occupancy;
    logic [MAP_W-1:0] maps_due [$];
    int errors;
    int maps_seen;
    int points_taken;

    function new();
      for (int i = 0; i < RINGS_MAX; i++) radius[i] = RADIUS_RST[i];
      occupancy = '0;
      errors = 0;
      maps_seen = 0;
      points_taken = 0;
    endfunction

    // Mark the cell a point falls in; on the final point queue the map.
    function void note_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                             logic last);
      longint sx, sy;
      longint unsigned ax, ay, dist_sq, lim, rise, run15, run45, run75;
      bit xneg, yneg;
      int ring, sector;
      sx = longint'(x);
      sy = longint'(y);
      xneg = sx < 0;
      yneg = sy < 0;
      ax = xneg ? -sx : sx;
      ay = yneg ? -sy : sy;
      dist_sq = ax * ax + ay * ay;
      // First ring in index order whose radius beats the distance wins.
      ring = -1;
      for (int i = 0; i < RINGS_DEF; i++) begin
        lim = 64'(radius[i]);
        if (ring < 0 && dist_sq < lim * lim) ring = i;
      end
      if (ring >= 0) begin
        rise  = ay << Q_FRAC;
        run15 = ax * longint'(TAN15_Q16);
        run45 = ax * TAN45_Q1616;
        run75 = ax * longint'(TAN75_Q16);
        if (ax == 0 && ay == 0) begin
          sector = 0;
        end else if (!xneg) begin
          // Boundaries fall outward: ties count toward the higher sector.
          sector = int'(rise >= run15) + int'(rise >= run45) + int'(rise >= run75);
        end else begin
          sector = SECT_HALF - (int'(rise > run15) + int'(rise > run45) + int'(rise > run75));
        end
        if (yneg) sector = (SECTORS - sector) % SECTORS;
        occupancy[ring * SECTORS + sector] = 1'b1;
      end
      points_taken++;
      if (last) begin
        maps_due = {maps_due, occupancy};
        occupancy = '0;
      end
    endfunction

    function void check_map(logic [MAP_W-1:0] got);
      logic [MAP_W-1:0] want;
      maps_seen++;
      if (maps_due.size() == 0) begin
        $error("occupied_map: no map expected, actual %h", got);
        errors++;
        return;
      end
      want = maps_due.pop_front();
      if (got !== want) begin
        $error("occupied_map: expected %h, actual %h", want, got);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RAD_W-1:0] cfg_data;

  pso_in_if  in_pt ();
  pso_out_if out_map ();

  polar_sector_occupancy #(.RINGS(RINGS_DEF)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pt     (in_pt),
    .out_map   (out_map),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  occupancy_scoreboard sb = new();

  bit calm = 1'b0;            // no idling on either side while set
  int holdoff_requests = 0;   // bumped by the stimulus, served by the receiver
  int holdoffs_started = 0;
  int settings_done = 0;
  int cycle_count = 0;

  // Radius settings, one per phase, and how each phase is driven.
  int unsigned ring_plan [PLANS][RINGS_MAX] = '{
    '{150, 450, 550, 1000},
    '{32767, 32767, 32767, 32767},
    '{0, 0, 0, 0},
    '{3000, 500, 32767, 0},
    '{0, 0, 0, 0},
    '{1, 2, 3, 4}
  };
  int plan_items [PLANS]    = '{260, 300, 40, 260, 280, 260};
  int plan_calm [PLANS]     = '{0, 200, 0, 0, 0, 0};
  bit plan_holdoff [PLANS]  = '{0, 0, 0, 1, 1, 0};

  // Directed points, run with radii 1000/8000/20000/32767: origin, axes, ring
  // edges, exact sector boundaries at 15 degrees in every quadrant and at 45/75
  // degrees in two, the coordinate extremes, and a final point that lands nowhere.
  int unsigned directed_radii [RINGS_MAX] = '{1000, 8000, 20000, 32767};
  int directed_pts [DIRECTED_N][3] = '{
    '{0, 0, 0},          '{999, 0, 0},        '{1000, 0, 0},
    '{0, 500, 0},        '{-500, 0, 0},       '{0, -500, 1},
    '{8192, 2195, 0},    '{-8192, 2195, 0},   '{8192, -2195, 0},
    '{-8192, -2195, 0},  '{3000, 3000, 0},    '{-3000, -3000, 0},
    '{8192, 30573, 0},   '{-8192, -30573, 0}, '{-32768, -32768, 0},
    '{32767, 0, 0},      '{32766, 0, 1},      '{-32768, 0, 1},
    '{0, 32767, 0},      '{-1, 0, 0},         '{0, -32768, 0},
    '{1, -1, 0},         '{-1, 1, 1}
  };

  // Build a coordinate from a magnitude and a sign, clamped to 16 bits.
  function automatic logic signed [COORD_W-1:0] to_coord(int mag, bit neg);
    int v;
    if (neg && mag > 32768) mag = 32768;
    if (!neg && mag > 32767) mag = 32767;
    v = neg ? -mag : mag;
    return v[COORD_W-1:0];
  endfunction

  // Offer one point; return at the falling edge after its transfer, valid
  // still high so that back-to-back points flow without a bubble.
  task automatic send_point(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y, input logic last);
    int gap;
    gap = 0;
    if (!calm) while ($urandom_range(0, 99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      in_pt.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_pt.valid     <= 1'b1;
    in_pt.point_x   <= x;
    in_pt.point_y   <= y;
    in_pt.scan_last <= last;
    do @(posedge clk); while (!in_pt.ready);
    sb.note_point(x, y, last);
    @(negedge clk);
  endtask

  // Write all four radii, one per cycle; only called while the block is idle.
  task automatic write_radii(input int unsigned radii [RINGS_MAX]);
    for (int i = 0; i < RINGS_MAX; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= radius_reg_e'(i);
      cfg_data  <= RAD_W'(radii[i]);
      sb.radius[i] = RAD_W'(radii[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  // Drop valid, wait for every queued map, then let the pipeline empty.
  task automatic wait_drained();
    in_pt.valid <= 1'b0;
    while (sb.maps_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Random scans of random length, each closed by a final point. Points are
  // mostly placed at the scale of the current radii so that rings, sectors
  // and their edges get hit; the rest are diagonals, axes, exact tangent
  // boundaries, ring edges and fully random coordinates.
  task automatic run_scans(input int items, input int calm_items);
    logic signed [COORD_W-1:0] px, py;
    int scan_left, scale, span, pick, ax, ay, j;
    bit swap;
    scan_left = $urandom_range(1, MAX_SCAN);
    for (int i = 0; i < items; i++) begin
      calm = (i < calm_items);
      scale = 4;
      for (int r = 0; r < RINGS_MAX; r++)
        if (int'(sb.radius[r]) > scale) scale = int'(sb.radius[r]);
      span = scale + scale / 8;
      if (span > 32768) span = 32768;
      pick = $urandom_range(0, 99);
      if (pick < 86) begin
        if (pick < 50) begin
          ax = $urandom_range(0, span);
          ay = $urandom_range(0, span);
        end else if (pick < 62) begin
          ax = $urandom_range(0, span);
          ay = ax;
        end else if (pick < 70) begin
          ax = $urandom_range(0, span);
          ay = 0;
        end else if (pick < 78) begin
          // exact 15 and 75 degree boundaries in Q16
          if ($urandom_range(0, 2) != 0) begin
            j = $urandom_range(1, 3);
            ax = 8192 * j;
            ay = 2195 * j;
          end else begin
            ax = 8192;
            ay = 30573;
          end
        end else begin
          // on or just inside a ring's radius
          ax = int'(sb.radius[$urandom_range(0, RINGS_MAX - 1)]) - int'($urandom_range(0, 1));
          if (ax < 0) ax = 0;
          ay = 0;
        end
        // swap onto the other axis for the axis and ring-edge cases
        swap = (pick >= 62 && pick < 70) || (pick >= 78 && $urandom_range(0, 1) != 0);
        if (swap) begin
          ay = ax;
          ax = 0;
        end
        px = to_coord(ax, $urandom_range(0, 1) != 0);
        py = to_coord(ay, $urandom_range(0, 1) != 0);
      end else begin
        px = COORD_W'($urandom());
        py = COORD_W'($urandom());
      end
      send_point(px, py, scan_left == 1 || i == items - 1);
      scan_left--;
      if (scan_left == 0) scan_left = $urandom_range(1, MAX_SCAN);
    end
    calm = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random ready, long hold-offs on request, no idling while calm
  // --------------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left = 0;
    out_map.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoffs_started != holdoff_requests) begin
        holdoffs_started++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_map.ready <= 1'b0;
      end else begin
        out_map.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Check each map transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_map.valid && out_map.ready) sb.check_map(out_map.occupied_map);
  end

  // Hang guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = RING0_RADIUS;
    cfg_data        = '0;
    in_pt.valid     = 1'b0;
    in_pt.point_x   = '0;
    in_pt.point_y   = '0;
    in_pt.scan_last = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed points first.
    write_radii(directed_radii);
    foreach (directed_pts[k])
      send_point(COORD_W'(directed_pts[k][0]), COORD_W'(directed_pts[k][1]),
                 directed_pts[k][2] != 0);
    wait_drained();

    // Random scans, one radius setting per phase; radii change only when idle.
    for (int p = 0; p < PLANS; p++) begin
      if (p == RANDOM_PLAN)
        for (int i = 0; i < RINGS_MAX; i++) ring_plan[p][i] = $urandom_range(0, 32767);
      write_radii(ring_plan[p]);
      if (plan_holdoff[p]) holdoff_requests++;
      run_scans(plan_items[p], plan_calm[p]);
      wait_drained();
    end

    if (sb.maps_due.size() != 0) begin
      $error("occupied_map: %0d expected maps never arrived", sb.maps_due.size());
      sb.errors++;
    end
    $display("tb: %0d points across %0d radius settings, %0d maps checked",
             sb.points_taken, settings_done, sb.maps_seen);
    $display("tb: %0d receiver hold-offs, %0d mismatches, %0d cycles",
             holdoffs_started, sb.errors, cycle_count);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
